// ===== design/atlas_slot_allocator_lru_assert.svh =====
// Assertion macros for the atlas slot allocator.
// Included by the top level; no other dependencies.
`ifndef ATLAS_SLOT_ALLOCATOR_LRU_ASSERT_SVH
`define ATLAS_SLOT_ALLOCATOR_LRU_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ASL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/asl_pkg.sv =====
// Shared types and constants for the atlas slot allocator.
// No dependencies.
package asl_pkg;

    localparam int OWNER_IN_W = 16;
    localparam int FRAME_W    = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int LIMIT_W    = 5;

    localparam logic [LIMIT_W-1:0] SLOTS_RESET = 5'd16;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_READY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 8'd1;

    typedef enum logic [2:0] {
        STAT_HELD     = 3'd0,
        STAT_FREE     = 3'd1,
        STAT_EVICT    = 3'd2,
        STAT_NONE     = 3'd3,
        STAT_NOTREADY = 3'd4,
        STAT_RELEASED = 3'd5,
        STAT_REFUSED  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot_index;
        logic                    evicted_valid;
        logic [OWNER_IN_W-1:0]   evicted_owner;
    } t_result;

    typedef struct packed {
        logic owner_hit;
        logic before_frame;
        logic below_best;
    } t_cmp;

endpackage

// ===== design/asl_if.sv =====
// Channel interfaces: request, result and register write.
// Depends on asl_pkg for field widths.
interface asl_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [asl_pkg::OWNER_IN_W-1:0]  owner_id;
    logic [asl_pkg::FRAME_W-1:0]     current_frame;

    modport source (output valid, kind, owner_id, current_frame, input ready);
    modport sink   (input valid, kind, owner_id, current_frame, output ready);
endinterface

interface asl_out_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      status;
    logic [asl_pkg::SLOT_OUT_W-1:0]  slot_index;
    logic                            evicted_valid;
    logic [asl_pkg::OWNER_IN_W-1:0]  evicted_owner;

    modport source (output valid, status, slot_index, evicted_valid, evicted_owner,
                    input ready);
    modport sink   (input valid, status, slot_index, evicted_valid, evicted_owner,
                    output ready);
endinterface

interface asl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [asl_pkg::CFG_IDX_W-1:0]   index;
    logic [asl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/asl_table.sv =====
// Slot table memory: holder and grant stamp per slot, one write, one read port.
// Depends on asl_pkg for the stamp width.
module asl_table #(
    parameter int NUM_SLOTS  = 16,
    parameter int OWNER_BITS = 16,
    parameter int SLOT_W     = 4
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [SLOT_W-1:0]             i_waddr,
    input  logic [OWNER_BITS-1:0]         i_wholder,
    input  logic [asl_pkg::FRAME_W-1:0]   i_wstamp,
    input  logic [SLOT_W-1:0]             i_raddr,
    output logic [OWNER_BITS-1:0]         o_rholder,
    output logic [asl_pkg::FRAME_W-1:0]   o_rstamp
);

    logic [OWNER_BITS-1:0]       r_holder [NUM_SLOTS];
    logic [asl_pkg::FRAME_W-1:0] r_stamp  [NUM_SLOTS];
    logic [OWNER_BITS-1:0]       r_rholder;
    logic [asl_pkg::FRAME_W-1:0] r_rstamp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_holder[i_waddr] <= i_wholder;
            r_stamp[i_waddr]  <= i_wstamp;
        end
        r_rholder <= r_holder[i_raddr];
        r_rstamp  <= r_stamp[i_raddr];
    end

    assign o_rholder = r_rholder;
    assign o_rstamp  = r_rstamp;

endmodule

// ===== design/asl_cmp.sv =====
// Shared compare unit: owner match and stamp age tests for one slot per cycle.
// Depends on asl_pkg for t_cmp and the stamp width.
module asl_cmp #(
    parameter int OWNER_BITS = 16
) (
    input  logic [OWNER_BITS-1:0]         i_holder,
    input  logic [OWNER_BITS-1:0]         i_owner,
    input  logic [asl_pkg::FRAME_W-1:0]   i_stamp,
    input  logic [asl_pkg::FRAME_W-1:0]   i_frame,
    input  logic [asl_pkg::FRAME_W-1:0]   i_best_stamp,
    output asl_pkg::t_cmp                 o_cmp
);

    always_comb begin
        o_cmp.owner_hit    = (i_holder == i_owner);
        o_cmp.before_frame = (i_stamp < i_frame);
        o_cmp.below_best   = (i_stamp < i_best_stamp);
    end

endmodule

// ===== design/atlas_slot_allocator_lru.sv =====
// Atlas slot allocator with least-recently-granted eviction: sequencer and top level.
// Depends on asl_pkg, asl_if, asl_table, asl_cmp and the assertion macro header.
//
//  channel  | dir | beat content
//  ---------+-----+-------------------------------------------------------
//  i_in     | in  | kind, owner_id, current_frame
//  o_out    | out | status, slot_index, evicted_valid, evicted_owner
//  i_cfg    | in  | index, data (register write)
//
// A request is taken only in idle; the table scan then reads and compares one slot per
// cycle, followed by the last, finish and result states. A request with the atlas not
// ready goes straight to the result state. Reset is synchronous and clears every slot
// to free. A result waits in the output register while the next request is taken;
// a second result waits until that register drains.
`include "atlas_slot_allocator_lru_assert.svh"

module atlas_slot_allocator_lru #(
    parameter int NUM_SLOTS  = 16,
    parameter int OWNER_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asl_in_if.sink     i_in,
    asl_out_if.source  o_out,
    asl_cfg_if.sink    i_cfg
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    asl_pkg::t_state                 r_state;
    asl_pkg::t_state                 n_state;

    logic                            r_atlas_ready;
    logic [asl_pkg::LIMIT_W-1:0]     r_slots_in_use;
    logic [NUM_SLOTS-1:0]            r_busy;

    logic                            r_kind;
    logic [OWNER_BITS-1:0]           r_owner;
    logic [asl_pkg::FRAME_W-1:0]     r_frame;

    logic [SLOT_W-1:0]               r_idx;
    logic                            r_chk_vld;
    logic [SLOT_W-1:0]               r_chk_idx;

    logic                            r_held_f;
    logic [SLOT_W-1:0]               r_held_i;
    logic                            r_free_f;
    logic [SLOT_W-1:0]               r_free_i;
    logic                            r_old_f;
    logic [SLOT_W-1:0]               r_old_i;
    logic [asl_pkg::FRAME_W-1:0]     r_old_stamp;
    logic [OWNER_BITS-1:0]           r_old_owner;

    asl_pkg::t_result                r_res;
    asl_pkg::t_result                n_res;
    logic                            r_ovld;
    asl_pkg::t_result                r_out;

    logic                            in_acc;
    logic                            cfg_acc;
    logic                            out_free;
    logic                            grant;
    logic [SLOT_W-1:0]               grant_i;
    logic                            in_lim;
    logic                            chk_busy;

    logic [OWNER_BITS-1:0]           rd_holder;
    logic [asl_pkg::FRAME_W-1:0]     rd_stamp;
    asl_pkg::t_cmp                   cmp;

    asl_table #(
        .NUM_SLOTS  (NUM_SLOTS),
        .OWNER_BITS (OWNER_BITS),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (r_state == asl_pkg::ST_FINISH && grant),
        .i_waddr   (grant_i),
        .i_wholder (r_owner),
        .i_wstamp  (r_frame),
        .i_raddr   (r_idx),
        .o_rholder (rd_holder),
        .o_rstamp  (rd_stamp)
    );

    asl_cmp #(
        .OWNER_BITS (OWNER_BITS)
    ) u_cmp (
        .i_holder     (rd_holder),
        .i_owner      (r_owner),
        .i_stamp      (rd_stamp),
        .i_frame      (r_frame),
        .i_best_stamp (r_old_stamp),
        .o_cmp        (cmp)
    );

    assign in_acc    = i_in.valid && i_in.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign out_free  = !r_ovld || o_out.ready;
    assign chk_busy  = r_busy[r_chk_idx];
    assign in_lim    = int'(r_chk_idx) < int'(r_slots_in_use);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        grant      = 1'b0;
        grant_i    = r_free_i;
        n_res      = r_res;
        unique case (r_state)
            asl_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = r_atlas_ready ? asl_pkg::ST_SCAN : asl_pkg::ST_EMIT;
                end
            end
            asl_pkg::ST_SCAN: begin
                if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = asl_pkg::ST_LAST;
                end
            end
            asl_pkg::ST_LAST: begin
                n_state = asl_pkg::ST_FINISH;
            end
            asl_pkg::ST_FINISH: begin
                n_state                = asl_pkg::ST_EMIT;
                n_res.slot_index       = '0;
                n_res.evicted_valid    = 1'b0;
                n_res.evicted_owner    = '0;
                if (r_kind == asl_pkg::KIND_RELEASE) begin
                    if (r_held_f) begin
                        n_res.status     = asl_pkg::STAT_RELEASED;
                        n_res.slot_index = asl_pkg::SLOT_OUT_W'(r_held_i);
                    end else begin
                        n_res.status     = asl_pkg::STAT_REFUSED;
                    end
                end else if (r_held_f) begin
                    n_res.status     = asl_pkg::STAT_HELD;
                    n_res.slot_index = asl_pkg::SLOT_OUT_W'(r_held_i);
                end else if (r_free_f) begin
                    grant            = 1'b1;
                    n_res.status     = asl_pkg::STAT_FREE;
                    n_res.slot_index = asl_pkg::SLOT_OUT_W'(r_free_i);
                end else if (r_old_f) begin
                    grant               = 1'b1;
                    grant_i             = r_old_i;
                    n_res.status        = asl_pkg::STAT_EVICT;
                    n_res.slot_index    = asl_pkg::SLOT_OUT_W'(r_old_i);
                    n_res.evicted_valid = 1'b1;
                    n_res.evicted_owner = asl_pkg::OWNER_IN_W'(r_old_owner);
                end else begin
                    n_res.status     = asl_pkg::STAT_NONE;
                end
            end
            asl_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = asl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = asl_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration, slot busy bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_ready  <= 1'b0;
            r_slots_in_use <= asl_pkg::SLOTS_RESET;
            r_busy         <= '0;
            r_ovld         <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    asl_pkg::REG_ATLAS_READY: begin
                        r_atlas_ready <= i_cfg.data[0];
                    end
                    asl_pkg::REG_SLOTS_IN_USE: begin
                        r_slots_in_use <= i_cfg.data[asl_pkg::LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == asl_pkg::ST_FINISH) begin
                if (grant) begin
                    r_busy[grant_i] <= 1'b1;
                end
                if (r_kind == asl_pkg::KIND_RELEASE && r_held_f) begin
                    r_busy[r_held_i] <= 1'b0;
                end
            end
            if (r_state == asl_pkg::ST_EMIT && out_free) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // request capture, scan pipeline and result payload
    always_ff @(posedge i_clk) begin
        r_chk_vld <= (r_state == asl_pkg::ST_SCAN);
        r_chk_idx <= r_idx;
        if (in_acc) begin
            r_kind   <= i_in.kind;
            r_owner  <= OWNER_BITS'(i_in.owner_id);
            r_frame  <= i_in.current_frame;
            r_idx    <= '0;
            r_held_f <= 1'b0;
            r_free_f <= 1'b0;
            r_old_f  <= 1'b0;
            r_res.status        <= asl_pkg::STAT_NOTREADY;
            r_res.slot_index    <= '0;
            r_res.evicted_valid <= 1'b0;
            r_res.evicted_owner <= '0;
        end else begin
            if (r_state == asl_pkg::ST_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == asl_pkg::ST_FINISH) begin
                r_res <= n_res;
            end
        end
        if (r_chk_vld) begin
            if (chk_busy && cmp.owner_hit && !r_held_f) begin
                r_held_f <= 1'b1;
                r_held_i <= r_chk_idx;
            end
            if (in_lim && !chk_busy && !r_free_f) begin
                r_free_f <= 1'b1;
                r_free_i <= r_chk_idx;
            end
            if (in_lim && chk_busy && !r_free_f && cmp.before_frame
                    && (!r_old_f || cmp.below_best)) begin
                r_old_f     <= 1'b1;
                r_old_i     <= r_chk_idx;
                r_old_stamp <= rd_stamp;
                r_old_owner <= rd_holder;
            end
        end
        if (r_state == asl_pkg::ST_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid         = r_ovld;
    assign o_out.status        = r_out.status;
    assign o_out.slot_index    = r_out.slot_index;
    assign o_out.evicted_valid = r_out.evicted_valid;
    assign o_out.evicted_owner = r_out.evicted_owner;

    `ASL_ASSERT_NEXT(a_notready_fast, i_clk, i_rst_n, in_acc && !r_atlas_ready, r_state == asl_pkg::ST_EMIT, "request with atlas not ready did not go straight to result")
    `ASL_ASSERT_NEXT(a_grant_marks_busy, i_clk, i_rst_n, r_state == asl_pkg::ST_FINISH && grant, r_busy[$past(grant_i)], "granted slot not marked busy")
    `ASL_ASSERT_NOW(a_evict_flag, i_clk, i_rst_n, o_out.valid, o_out.evicted_valid == (o_out.status == asl_pkg::STAT_EVICT), "evicted flag disagrees with status")
    `ASL_ASSERT_NOW(a_scan_busy, i_clk, i_rst_n, r_state != asl_pkg::ST_IDLE, !in_acc, "request accepted during scan")

endmodule
